// File: sv/dpsq_pkg.sv
package dpsq_pkg;

  // request modes
  localparam logic [1:0] MODE_ARRIVE      = 2'd0;
  localparam logic [1:0] MODE_SERVE_FIRST = 2'd1;

  // result status codes
  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_SERVED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam int NUM_W = 32;
  localparam int VAL_W = 20;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [NUM_W-1:0] number;
  } rsp_t;

  // one table entry as kept in the slot memory
  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] number;
    logic [VAL_W-1:0] value;
  } entry_t;

  // sequencer to compare unit
  typedef struct packed {
    logic clear;
    logic sample;
    logic by_value;
  } pick_ctrl_t;

  // compare unit back to sequencer
  typedef struct packed {
    logic             free_found;
    logic             best_found;
    logic [NUM_W-1:0] best_number;
    logic [VAL_W-1:0] best_value;
  } pick_stat_t;

endpackage

// File: sv/dpsq_table.sv
module dpsq_table #(
  parameter int SLOTS = 64,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  dpsq_pkg::entry_t    wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output dpsq_pkg::entry_t    rdata
);

  dpsq_pkg::entry_t mem [SLOTS];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/dpsq_pick.sv
module dpsq_pick #(
  parameter int IDX_W = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dpsq_pkg::pick_ctrl_t ctrl,
  input  logic [IDX_W-1:0]     idx,
  input  dpsq_pkg::entry_t     entry,
  output dpsq_pkg::pick_stat_t stat,
  output logic [IDX_W-1:0]     free_idx,
  output logic [IDX_W-1:0]     best_idx
);

  logic better;
  logic take_free;
  logic take_best;

  // shared comparator: candidate entry against the current best
  always_comb begin
    if (ctrl.by_value) begin
      better = (entry.value > stat.best_value) ||
               ((entry.value == stat.best_value) && (entry.number < stat.best_number));
    end else begin
      better = entry.number < stat.best_number;
    end
    take_free = ctrl.sample && !entry.busy && !stat.free_found;
    take_best = ctrl.sample && entry.busy && (!stat.best_found || better);
  end

  // found flags, running lowest free slot and best busy slot
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      stat.free_found <= 1'b0;
      stat.best_found <= 1'b0;
    end else begin
      if (take_free) begin
        stat.free_found <= 1'b1;
      end
      if (take_best) begin
        stat.best_found <= 1'b1;
      end
    end
    if (take_free) begin
      free_idx <= idx;
    end
    if (take_best) begin
      best_idx         <= idx;
      stat.best_number <= entry.number;
      stat.best_value  <= entry.value;
    end
  end

endmodule

// File: sv/dual_policy_service_queue_core.sv
// a result strobes on done after the scan, drain and commit states, one beat per request
// a new request is taken only while idle; busy stays high for the whole scan
// every request reads all slots once through one read port and one shared comparator
// reset: a clearing pass writes every slot empty, with busy high
// the receiver cannot stall: each result is shown for exactly one cycle on done
module dual_policy_service_queue_core #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dpsq_pkg::req_t req,
  output logic           done,
  output dpsq_pkg::rsp_t rsp
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  dpsq_pkg::state_t state;
  dpsq_pkg::state_t state_next;

  logic [IDX_W-1:0]             addr;
  logic                         rd_vld;
  logic [IDX_W-1:0]             rd_idx;
  logic [1:0]                   mode;
  logic [dpsq_pkg::VAL_W-1:0]   value;
  logic [dpsq_pkg::NUM_W-1:0]   next_number;
  logic [dpsq_pkg::NUM_W-1:0]   next_number_next;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  dpsq_pkg::entry_t      mem_wdata;
  logic                  mem_re;
  dpsq_pkg::entry_t      mem_rdata;

  dpsq_pkg::pick_ctrl_t  pick_ctrl;
  dpsq_pkg::pick_stat_t  pick_stat;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W-1:0]      best_idx;

  dpsq_pkg::rsp_t        rsp_next;
  logic                  accept;

  assign busy   = (state != dpsq_pkg::S_IDLE);
  assign accept = start && !busy;

  dpsq_table #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  dpsq_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (pick_ctrl),
    .idx      (rd_idx),
    .entry    (mem_rdata),
    .stat     (pick_stat),
    .free_idx (free_idx),
    .best_idx (best_idx)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dpsq_pkg::S_CLEAR: begin
        if (addr == LAST) begin
          state_next = dpsq_pkg::S_IDLE;
        end
      end
      dpsq_pkg::S_IDLE: begin
        if (start) begin
          state_next = dpsq_pkg::S_SCAN;
        end
      end
      dpsq_pkg::S_SCAN: begin
        if (addr == LAST) begin
          state_next = dpsq_pkg::S_DRAIN;
        end
      end
      dpsq_pkg::S_DRAIN: begin
        state_next = dpsq_pkg::S_COMMIT;
      end
      dpsq_pkg::S_COMMIT: begin
        state_next = dpsq_pkg::S_IDLE;
      end
      default: begin
        state_next = dpsq_pkg::S_IDLE;
      end
    endcase
  end

  // outputs: memory, compare unit control and the commit decision
  always_comb begin
    mem_we             = 1'b0;
    mem_waddr          = addr;
    mem_wdata          = '0;
    mem_re             = 1'b0;
    pick_ctrl.clear    = 1'b0;
    pick_ctrl.sample   = rd_vld;
    pick_ctrl.by_value = (mode != dpsq_pkg::MODE_SERVE_FIRST);
    next_number_next   = next_number;
    rsp_next.status    = dpsq_pkg::ST_EMPTY;
    rsp_next.number    = '0;
    case (state)
      dpsq_pkg::S_CLEAR: begin
        mem_we = 1'b1;
      end
      dpsq_pkg::S_IDLE: begin
        pick_ctrl.clear = 1'b1;
      end
      dpsq_pkg::S_SCAN: begin
        mem_re = 1'b1;
      end
      dpsq_pkg::S_DRAIN: begin
        mem_re = 1'b0;
      end
      dpsq_pkg::S_COMMIT: begin
        if (mode == dpsq_pkg::MODE_ARRIVE) begin
          if (pick_stat.free_found && (next_number != '0)) begin
            mem_we           = 1'b1;
            mem_waddr        = free_idx;
            mem_wdata.busy   = 1'b1;
            mem_wdata.number = next_number;
            mem_wdata.value  = value;
            next_number_next = next_number + 1'b1;
            rsp_next.status  = dpsq_pkg::ST_STORED;
            rsp_next.number  = next_number;
          end else begin
            rsp_next.status  = dpsq_pkg::ST_FULL;
          end
        end else if (pick_stat.best_found) begin
          mem_we           = 1'b1;
          mem_waddr        = best_idx;
          mem_wdata.busy   = 1'b0;
          mem_wdata.number = pick_stat.best_number;
          mem_wdata.value  = pick_stat.best_value;
          rsp_next.status  = dpsq_pkg::ST_SERVED;
          rsp_next.number  = pick_stat.best_number;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= dpsq_pkg::S_CLEAR;
      addr        <= '0;
      rd_vld      <= 1'b0;
      next_number <= dpsq_pkg::NUM_W'(1);
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      rd_vld      <= (state == dpsq_pkg::S_SCAN);
      next_number <= next_number_next;
      done        <= (state == dpsq_pkg::S_COMMIT);
      if ((state == dpsq_pkg::S_CLEAR) || (state == dpsq_pkg::S_SCAN)) begin
        addr <= (addr == LAST) ? '0 : addr + 1'b1;
      end else begin
        addr <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= addr;
    if (accept) begin
      mode  <= req.mode;
      value <= req.value;
    end
    if (state == dpsq_pkg::S_COMMIT) begin
      rsp <= rsp_next;
    end
  end

  // a taken request keeps the block busy for its scan
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy did not rise after start was taken");

  // a result only follows a commit step
  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == dpsq_pkg::S_COMMIT)
    else $error("result strobe without a commit step");

  // a stored request gets the number just handed out
  a_store_number: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == dpsq_pkg::ST_STORED)) |->
      (rsp.number == dpsq_pkg::NUM_W'(next_number - 1'b1)))
    else $error("stored number does not match the arrival counter");

  // dropped arrivals and empty serves carry no number
  a_zero_number: assert property (@(posedge clk) disable iff (rst)
    (done && ((rsp.status == dpsq_pkg::ST_FULL) || (rsp.status == dpsq_pkg::ST_EMPTY)))
      |-> (rsp.number == '0))
    else $error("nonzero number on a full or empty result");

  // the arrival counter moves only on a store
  a_counter_hold: assert property (@(posedge clk) disable iff (rst)
    (state != dpsq_pkg::S_COMMIT) |=> $stable(next_number))
    else $error("arrival counter moved outside a commit");

endmodule

// File: sim/dpsq_service_checker.sv
`timescale 1ns / 100ps

module dpsq_service_checker #(
  parameter int SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  dpsq_pkg::req_t req,
  input  logic           done,
  input  dpsq_pkg::rsp_t rsp,
  output int             fail_count,
  output int             awaited
);

  // shadow copy of the request table
  logic                       tbl_busy [SLOTS];
  logic [dpsq_pkg::NUM_W-1:0] tbl_num  [SLOTS];
  logic [dpsq_pkg::VAL_W-1:0] tbl_val  [SLOTS];
  logic [dpsq_pkg::NUM_W-1:0] next_num;

  dpsq_pkg::rsp_t awaited_rsp[$];
  int             errs = 0;

  // apply one request to the shadow table, return the outcome it should give
  function automatic dpsq_pkg::rsp_t predict_service(dpsq_pkg::req_t r);
    dpsq_pkg::rsp_t res;
    int             pick;
    res.status = dpsq_pkg::ST_FULL;
    res.number = '0;
    pick = -1;
    if (r.mode == dpsq_pkg::MODE_ARRIVE) begin
      // lowest free slot, drop when full or numbers are used up
      for (int k = 0; k < SLOTS; k++) begin
        if (pick < 0 && !tbl_busy[k]) pick = k;
      end
      if (pick >= 0 && next_num != '0) begin
        tbl_busy[pick] = 1'b1;
        tbl_num[pick]  = next_num;
        tbl_val[pick]  = r.value;
        res.status     = dpsq_pkg::ST_STORED;
        res.number     = next_num;
        next_num       = next_num + 1'b1;
      end
    end else begin
      // earliest arrival, or highest value with ties to the earliest
      for (int k = 0; k < SLOTS; k++) begin
        if (tbl_busy[k]) begin
          if (pick < 0) begin
            pick = k;
          end else if (r.mode != dpsq_pkg::MODE_SERVE_FIRST) begin
            if (tbl_val[k] > tbl_val[pick] ||
                (tbl_val[k] == tbl_val[pick] && tbl_num[k] < tbl_num[pick]))
              pick = k;
          end else if (tbl_num[k] < tbl_num[pick]) begin
            pick = k;
          end
        end
      end
      if (pick < 0) begin
        res.status = dpsq_pkg::ST_EMPTY;
      end else begin
        res.status     = dpsq_pkg::ST_SERVED;
        res.number     = tbl_num[pick];
        tbl_busy[pick] = 1'b0;
      end
    end
    return res;
  endfunction

  // watch both channels at every edge
  always @(posedge clk) begin : watch
    dpsq_pkg::rsp_t want;
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        tbl_busy[k] = 1'b0;
        tbl_num[k]  = '0;
        tbl_val[k]  = '0;
      end
      next_num = dpsq_pkg::NUM_W'(1);
      awaited_rsp.delete();
    end else begin
      // result beat against the oldest prediction
      if (done) begin
        if (awaited_rsp.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: result with none awaited: status %0d number %0d",
                     $realtime, rsp.status, rsp.number);
        end else begin
          want = awaited_rsp.pop_front();
          if (want.status !== rsp.status || want.number !== rsp.number) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch: status exp %0d got %0d, number exp %0d got %0d",
                       $realtime, want.status, rsp.status, want.number, rsp.number);
          end
        end
      end
      // request beat taken
      if (start && !busy) begin
        want        = predict_service(req);
        awaited_rsp = {awaited_rsp, want};
      end
    end
    awaited    <= awaited_rsp.size();
    fail_count <= errs;
  end

endmodule

// File: sim/tb_dual_policy_service_queue_core.sv
`timescale 1ns / 100ps

module tb_dual_policy_service_queue_core;

  localparam int SLOTS = 64;
  localparam int RANDOM_ITEMS = 930;
  // serve by value, and the spare code that behaves the same
  localparam logic [1:0] MODE_SERVE_TOP = 2'd2;
  localparam logic [1:0] MODE_SERVE_ALT = 2'd3;
  localparam logic [dpsq_pkg::VAL_W-1:0] VAL_MAX = '1;

  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  dpsq_pkg::req_t req   = '0;
  logic           busy;
  logic           done;
  dpsq_pkg::rsp_t rsp;
  int             fail_count;
  int             awaited;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dual_policy_service_queue_core #(.SLOTS(SLOTS)) DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  dpsq_service_checker #(.SLOTS(SLOTS)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .done       (done),
    .rsp        (rsp),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  // present one request beat after an idle gap, return once it is taken
  task automatic send(input logic [1:0] m, input logic [dpsq_pkg::VAL_W-1:0] v,
                      input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    req.mode   <= m;
    req.value  <= v;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every outstanding result has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin : stim
    int sent;
    int rnd;
    int round_len;
    int arrive_pct;
    bit quiet;
    logic [1:0] m;
    logic [dpsq_pkg::VAL_W-1:0] v;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // serves on an empty table
    send(dpsq_pkg::MODE_SERVE_FIRST, VAL_MAX, 0);
    send(MODE_SERVE_TOP, '0, $urandom_range(0, 11));
    send(MODE_SERVE_ALT, 20'h5A5A5, 0);
    // value extremes and a tie on the top value
    send(dpsq_pkg::MODE_ARRIVE, '0, $urandom_range(0, 11));
    send(dpsq_pkg::MODE_ARRIVE, VAL_MAX, 0);
    send(dpsq_pkg::MODE_ARRIVE, VAL_MAX, $urandom_range(0, 11));
    send(dpsq_pkg::MODE_ARRIVE, 20'd5, 0);
    send(dpsq_pkg::MODE_ARRIVE, '0, 0);
    send(MODE_SERVE_ALT, '0, $urandom_range(0, 11));
    send(MODE_SERVE_TOP, VAL_MAX, 0);
    send(dpsq_pkg::MODE_SERVE_FIRST, 20'h12345, 0);
    send(MODE_SERVE_TOP, '0, $urandom_range(0, 11));
    send(MODE_SERVE_TOP, '0, 0);
    send(dpsq_pkg::MODE_SERVE_FIRST, '0, 0);
    // alternating bit patterns
    send(dpsq_pkg::MODE_ARRIVE, 20'hAAAAA, $urandom_range(0, 11));
    send(dpsq_pkg::MODE_ARRIVE, 20'h55555, 0);
    send(dpsq_pkg::MODE_SERVE_FIRST, '0, 0);
    send(MODE_SERVE_TOP, '0, 0);
    wait_idle();

    // random rounds, each leaning toward arrivals or serves
    sent = 0;
    rnd  = 0;
    while (sent < RANDOM_ITEMS) begin
      if (rnd == 0) begin
        // fill past capacity so the full case is hit early
        round_len  = SLOTS + 16;
        arrive_pct = 100;
      end else begin
        round_len = $urandom_range(30, 90);
        case ($urandom_range(0, 3))
          0: arrive_pct = 15;
          1: arrive_pct = 50;
          2: arrive_pct = 85;
          default: arrive_pct = 100;
        endcase
      end
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < round_len && sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(1, 100) <= arrive_pct) begin
          m = dpsq_pkg::MODE_ARRIVE;
        end else begin
          case ($urandom_range(0, 4))
            0, 1: m = dpsq_pkg::MODE_SERVE_FIRST;
            2, 3: m = MODE_SERVE_TOP;
            default: m = MODE_SERVE_ALT;
          endcase
        end
        // mix of full range, tight range for ties and the extremes
        case ($urandom_range(0, 3))
          0: v = dpsq_pkg::VAL_W'($urandom_range(0, 3));
          1: v = $urandom_range(0, 1) ? VAL_MAX : '0;
          default: v = dpsq_pkg::VAL_W'($urandom);
        endcase
        send(m, v, quiet ? 0 : $urandom_range(0, 11));
        sent++;
      end
      if (rnd == 1 || $urandom_range(0, 3) == 0) wait_idle();
      rnd++;
    end

    // let everything drain
    wait_idle();
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("dual_policy_service_queue_core verification clean");
    end else begin
      $display("dual_policy_service_queue_core verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("dual_policy_service_queue_core verification failed");
    $finish;
  end

endmodule

// File: files.f
sv/dpsq_pkg.sv
sv/dpsq_table.sv
sv/dpsq_pick.sv
sv/dual_policy_service_queue_core.sv
sim/dpsq_service_checker.sv
sim/tb_dual_policy_service_queue_core.sv
